### design/additive_harmonic_sample_generator_unit_macros.svh
// ----------------------------------------------------------------------------
// additive harmonic sample generator assertion macros
// shared property templates for the generator's checks
// ----------------------------------------------------------------------------
`ifndef ADDITIVE_HARMONIC_SAMPLE_GENERATOR_UNIT_MACROS_SVH
`define ADDITIVE_HARMONIC_SAMPLE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define AHS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AHS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ahs_pkg.sv
// ----------------------------------------------------------------------------
// ahs_pkg
// shared types, constants and the sine table generator
// ----------------------------------------------------------------------------
package ahs_pkg;

  localparam int IDX_IN_W  = 20;
  localparam int STEP_W    = 32;
  localparam int AMP_W     = 16;
  localparam int HARM_W    = 32;
  localparam int OUT_W     = 24;
  localparam int TERM_W    = 48;
  localparam int SUM_W     = 51;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC_0     = 3'd1;

  localparam logic [2:0]        COUNT_RESET      = 3'd1;
  localparam logic [HARM_W-1:0] HARMONIC_0_RESET = 32'h0100_8000;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic                    valid;
    logic [STEP_W-1:0]       step;
    logic [AMP_W-1:0]        amp;
    logic signed [SUM_W-1:0] sum;
  } link_t;

  // quarter-wave sine entry, signed q1.15 magnitude
  function automatic logic [15:0] sine_entry(input int k, input int b);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] sq;
    logic [63:0] r;
    x  = (64'd1686629713 * (64'(k) * 64'd2 + 64'd1)) >> (b + 1);
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
    t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
    sq = (x * t) >> 30;
    r  = (sq * 64'd32767 + (64'd1 << 29)) >> 30;
    return r[15:0];
  endfunction

endpackage

### design/ahs_cell.sv
// ----------------------------------------------------------------------------
// ahs_cell
// one harmonic: phase, sine lookup, scaling and accumulation in five stages
// ----------------------------------------------------------------------------
module ahs_cell #(
  parameter int INDEX_BITS      = 20,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       cell_act,
  input  logic [ahs_pkg::HARM_W-1:0] harm,
  input  ahs_pkg::link_t             link_i,
  input  logic [INDEX_BITS-1:0]      idx_i,
  output ahs_pkg::link_t             link_o,
  output logic [INDEX_BITS-1:0]      idx_o
);

  localparam int ROM_DEPTH = 1 << SINE_TABLE_BITS;
  localparam int PROD_W    = 32 + INDEX_BITS;
  localparam int SUM_W     = ahs_pkg::SUM_W;
  localparam int TERM_W    = ahs_pkg::TERM_W;

  logic [15:0] rom_tbl [ROM_DEPTH];

  for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
    localparam logic [15:0] ROM_VAL = ahs_pkg::sine_entry(g, SINE_TABLE_BITS);
    assign rom_tbl[g] = ROM_VAL;
  end

  // pass-along registers per stage
  logic [4:0]                      v_r;
  ahs_pkg::link_t                  lk_r   [5];
  logic [INDEX_BITS-1:0]           idx_r  [5];

  logic [39:0]                     p1_r;
  logic [31:0]                     ap1_r, ap2_r, ap3_r;
  logic [31:0]                     phase2_r;
  logic [15:0]                     rom3_r;
  logic                            neg3_r, neg4_r;
  logic [TERM_W-1:0]               mag4_r;
  logic signed [SUM_W-1:0]         sum5_r;

  logic [47:0]                     p_full;
  logic [PROD_W-1:0]               prod_lo;
  logic [15:0]                     prod_hi;
  logic [39:0]                     phase40;
  logic [SINE_TABLE_BITS-1:0]      rom_addr;
  logic signed [SUM_W-1:0]         mag_ext, delta, sum5_nxt;

  assign p_full  = link_i.step * harm[31:16];
  assign prod_lo = p1_r[31:0] * idx_r[0];
  assign prod_hi = p1_r[39:32] * idx_r[0][7:0];
  assign phase40 = prod_lo[39:0] + {prod_hi[7:0], 32'd0};

  always_comb begin
    rom_addr = phase2_r[29 -: SINE_TABLE_BITS];
    if (phase2_r[30]) begin
      rom_addr = ~rom_addr;
    end
  end

  assign mag_ext  = $signed({{(SUM_W - TERM_W){1'b0}}, mag4_r});
  assign delta    = cell_act ? (neg4_r ? -mag_ext : mag_ext) : '0;
  assign sum5_nxt = lk_r[3].sum + delta;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[3:0], link_i.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lk_r[0]  <= link_i;
      idx_r[0] <= idx_i;
      for (int s = 1; s < 5; s++) begin
        lk_r[s]  <= lk_r[s-1];
        idx_r[s] <= idx_r[s-1];
      end
      p1_r     <= p_full[39:0];
      ap1_r    <= link_i.amp * harm[15:0];
      phase2_r <= phase40[39:8];
      ap2_r    <= ap1_r;
      rom3_r   <= rom_tbl[rom_addr];
      neg3_r   <= phase2_r[31];
      ap3_r    <= ap2_r;
      mag4_r   <= ap3_r * rom3_r;
      neg4_r   <= neg3_r;
      sum5_r   <= sum5_nxt;
    end
  end

  always_comb begin
    link_o       = lk_r[4];
    link_o.valid = v_r[4];
    link_o.sum   = sum5_r;
  end

  assign idx_o = idx_r[4];

endmodule

### design/additive_harmonic_sample_generator_unit.sv
// Additive harmonic sample generator. Each item (sample index, pitch step,
// note amplitude) yields one 24-bit sample: the rounded, saturated sum over
// the first harmonic_count harmonics of amplitude x factor x sine(phase).
// The datapath is a row of MAX_HARMONICS identical cells, each adding one
// harmonic over five pipeline stages, followed by a round/saturate stage.
// One item is accepted per clock while in_ready is high. The pipeline
// stalls only while a result waits in the output skid register.
// Configuration writes must be made while idle.
// ----------------------------------------------------------------------------
// additive_harmonic_sample_generator_unit
// top level: config registers, cell chain, rounding and output skid buffer
// ----------------------------------------------------------------------------
`include "additive_harmonic_sample_generator_unit_macros.svh"

module additive_harmonic_sample_generator_unit #(
  parameter int MAX_HARMONICS   = 7,
  parameter int SINE_TABLE_BITS = 10,
  parameter int INDEX_BITS      = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ahs_pkg::IDX_IN_W-1:0]  in_sample_index,
  input  logic [ahs_pkg::STEP_W-1:0]    in_pitch_step,
  input  logic [ahs_pkg::AMP_W-1:0]     in_note_amplitude,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ahs_pkg::OUT_W-1:0] out_sample_value,
  input  logic                          cfg_wr_en,
  input  logic [ahs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ahs_pkg::HARM_W-1:0]    cfg_wdata
);

  localparam int SUM_W = ahs_pkg::SUM_W;
  localparam int SHR_W = SUM_W - 23;
  localparam int OUT_W = ahs_pkg::OUT_W;

  logic [2:0]                  count_r;
  logic [ahs_pkg::HARM_W-1:0]  harm_r [MAX_HARMONICS];

  ahs_pkg::link_t              chain     [MAX_HARMONICS+1];
  logic [INDEX_BITS-1:0]       idx_chain [MAX_HARMONICS+1];

  logic                        en;
  logic [31:0]                 idx_ext;
  logic signed [SUM_W-1:0]     rnd;
  logic signed [SHR_W-1:0]     shr;
  logic signed [OUT_W-1:0]     sat;

  logic                        out_valid_r, skid_v_r;
  logic signed [OUT_W-1:0]     out_data_r, skid_data_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= ahs_pkg::COUNT_RESET;
      for (int h = 0; h < MAX_HARMONICS; h++) begin
        harm_r[h] <= (h == 0) ? ahs_pkg::HARMONIC_0_RESET : '0;
      end
    end else if (cfg_wr_en) begin
      if (cfg_index == ahs_pkg::REG_HARMONIC_COUNT) begin
        count_r <= cfg_wdata[2:0];
      end
      for (int h = 0; h < MAX_HARMONICS; h++) begin
        if (int'(cfg_index) == int'(ahs_pkg::REG_HARMONIC_0) + h) begin
          harm_r[h] <= cfg_wdata;
        end
      end
    end
  end

  assign en       = !skid_v_r;
  assign in_ready = en;
  assign idx_ext  = 32'(in_sample_index);

  assign chain[0].valid = in_valid && in_ready;
  assign chain[0].step  = in_pitch_step;
  assign chain[0].amp   = in_note_amplitude;
  assign chain[0].sum   = '0;
  assign idx_chain[0]   = idx_ext[INDEX_BITS-1:0];

  for (genvar g = 0; g < MAX_HARMONICS; g++) begin : g_cell
    ahs_cell #(
      .INDEX_BITS      (INDEX_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .cell_act (count_r > 3'(g)),
      .harm     (harm_r[g]),
      .link_i   (chain[g]),
      .idx_i    (idx_chain[g]),
      .link_o   (chain[g+1]),
      .idx_o    (idx_chain[g+1])
    );
  end

  // round to nearest, then saturate
  assign rnd = chain[MAX_HARMONICS].sum + SUM_W'(1 << 22);
  assign shr = rnd[SUM_W-1:23];

  always_comb begin
    if (shr[SHR_W-1:OUT_W-1] == '0 || shr[SHR_W-1:OUT_W-1] == '1) begin
      sat = shr[OUT_W-1:0];
    end else if (shr[SHR_W-1]) begin
      sat = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  // output register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= chain[MAX_HARMONICS].valid;
      end
    end else if (chain[MAX_HARMONICS].valid && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_v_r ? skid_data_r : sat;
    end else if (en) begin
      skid_data_r <= sat;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = out_data_r;

  `AHS_ASSERT_IMP(a_skid_needs_out, clk, rst_n, skid_v_r, out_valid_r, "skid full with empty output")
  `AHS_ASSERT_NXT(a_skid_held, clk, rst_n, skid_v_r && out_valid_r && !out_ready, skid_v_r && $stable(skid_data_r), "skid item lost while output stalled")
  `AHS_ASSERT_IMP(a_skid_fill, clk, rst_n, $rose(skid_v_r), $past(out_valid_r && !out_ready && chain[MAX_HARMONICS].valid), "skid filled without a stalled result")

endmodule
